// ----- hdl/gtzs_pkg.sv -----
`default_nettype none

package gtzs_pkg;

    // Default sizes of the sample history.
    localparam int GRADIENT_LAG_DEF = 100;
    localparam int MAX_PRE_DEF      = 1024;

    // Field widths of the stream and of the registers.
    localparam int SAMPLE_W  = 16;
    localparam int INDEX_W   = 32;
    localparam int PRE_W     = 11;
    localparam int POST_W    = 16;
    localparam int SPACING_W = 17;
    localparam int KEEP_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    // Queue between the classifying front and the trigger back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QSUM_W      = QCNT_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACING = 2'd3;

    // One classified sample, as handed from the front to the back end.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;    // Current sample.
        logic signed [SAMPLE_W-1:0] old_g;     // Sample one gradient lag back.
        logic signed [SAMPLE_W-1:0] old_k;     // Sample leaving the delay line.
        logic                       grad_ok;   // A gradient exists for this sample.
        logic                       emit_ok;   // The delayed sample has a valid index.
        logic [INDEX_W-1:0]         trig_idx;  // Trigger index of the gradient.
        logic [INDEX_W-1:0]         out_idx;   // Index of the delayed sample.
        logic [KEEP_W-1:0]          total;     // Segment length of a trigger.
        logic                       rec_end;   // Last sample of a record.
    } t_item;

endpackage

`default_nettype wire

// ----- hdl/gradient_trigger_zero_suppress_unit.sv -----
// Zero-suppressing gradient trigger: takes one signed 16-bit sample per clock unless stalled and
// passes on only the samples around falling edges, each with its index in the record and first/last
// segment marks. A sustained rate of one sample per clock is reached on both sides when neither
// stalls; a kept sample goes through the front registers, a queue entry and the output register after
// the transfer of the sample that releases it, and that sample arrives GRADIENT_LAG + pre_count samples
// after the kept one. The rate is set by the sample history memory of GRADIENT_LAG + MAX_PRE words,
// which takes one write and two reads each cycle. A four-entry queue separates the classifying front
// from the trigger back end, so an output stall holds off the input only once that queue, with the
// item in flight, fills. The history needs no clearing pass: a fill count marks which entries belong
// to the current record, after reset and after block_end alike. Registers are written through the
// plain write port, by the user only while the block is idle; the block does not enforce this.
`default_nettype none

module gradient_trigger_zero_suppress_unit #(
    parameter int GRADIENT_LAG = gtzs_pkg::GRADIENT_LAG_DEF,
    parameter int MAX_PRE      = gtzs_pkg::MAX_PRE_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_stall,
    input  wire  signed [gtzs_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire                                    i_block_end,
    output logic                                   o_out_valid,
    input  wire                                    i_out_stall,
    output logic signed [gtzs_pkg::SAMPLE_W-1:0]   o_kept_sample,
    output logic [gtzs_pkg::INDEX_W-1:0]           o_sample_index,
    output logic                                   o_segment_first,
    output logic                                   o_segment_last,
    input  wire                                    i_cfg_we,
    input  wire  [gtzs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [gtzs_pkg::CFG_DAT_W-1:0]         i_cfg_data
);
    import gtzs_pkg::*;

    localparam int PE_CAP = (MAX_PRE > (2 ** PRE_W) - 1) ? (2 ** PRE_W) - 1 : MAX_PRE;

    // Configuration registers.
    logic signed [SAMPLE_W-1:0] r_threshold;
    logic [PRE_W-1:0]           r_pre_count;
    logic [POST_W-1:0]          r_post_count;
    logic [SPACING_W-1:0]       r_min_spacing;

    logic [PRE_W-1:0]  pre_eff;
    logic              q_push;
    t_item             q_in;
    logic              q_pop;
    logic              q_valid;
    t_item             q_out;
    logic [QCNT_W-1:0] q_count;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= '0;
            r_pre_count   <= '0;
            r_post_count  <= '0;
            r_min_spacing <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data[SAMPLE_W-1:0];
                CFG_PRE_COUNT:   r_pre_count   <= i_cfg_data[PRE_W-1:0];
                CFG_POST_COUNT:  r_post_count  <= i_cfg_data[POST_W-1:0];
                CFG_MIN_SPACING: r_min_spacing <= i_cfg_data[SPACING_W-1:0];
            endcase
        end
    end

    // The pre-trigger length saturates at the history capacity.
    assign pre_eff = (r_pre_count > PRE_W'(PE_CAP)) ? PRE_W'(PE_CAP) : r_pre_count;

    gtzs_front #(
        .GRADIENT_LAG (GRADIENT_LAG),
        .MAX_PRE      (MAX_PRE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_block_end  (i_block_end),
        .i_pre_eff    (pre_eff),
        .i_post_count (r_post_count),
        .i_q_count    (q_count),
        .o_push       (q_push),
        .o_item       (q_in)
    );

    gtzs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out),
        .o_count (q_count)
    );

    gtzs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_item          (q_out),
        .o_pop           (q_pop),
        .i_threshold     (r_threshold),
        .i_min_spacing   (r_min_spacing),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kept_sample   (o_kept_sample),
        .o_sample_index  (o_sample_index),
        .o_segment_first (o_segment_first),
        .o_segment_last  (o_segment_last)
    );

    // The queue never has to take more than it can hold.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QSUM_W'(q_count) + QSUM_W'(q_push)) <= QSUM_W'(QUEUE_DEPTH))
        else $error("front pushed into a full queue");

    // A new result only ever comes from an item taken out of the queue.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(q_pop))
        else $error("result appeared without a queue item");

    // An item is never taken from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_count != '0))
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- hdl/gtzs_front.sv -----
`default_nettype none

module gtzs_front #(
    parameter int GRADIENT_LAG = gtzs_pkg::GRADIENT_LAG_DEF,
    parameter int MAX_PRE      = gtzs_pkg::MAX_PRE_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_stall,
    input  wire  signed [gtzs_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire                                    i_block_end,
    input  wire  [gtzs_pkg::PRE_W-1:0]             i_pre_eff,
    input  wire  [gtzs_pkg::POST_W-1:0]            i_post_count,
    input  wire  [gtzs_pkg::QCNT_W-1:0]            i_q_count,
    output logic                                   o_push,
    output gtzs_pkg::t_item                        o_item
);
    import gtzs_pkg::*;

    localparam int DEPTH    = GRADIENT_LAG + MAX_PRE;
    localparam int AW       = $clog2(DEPTH);
    localparam int KW       = $clog2(DEPTH + 1);
    localparam int FW       = $clog2(DEPTH + 2);
    localparam int FILL_CAP = DEPTH + 1;

    localparam logic [KW-1:0] LAG_K   = KW'(GRADIENT_LAG);
    localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);

    // Sample history and its pointers.
    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic [AW-1:0]              r_wr_ptr;
    logic [FW-1:0]              r_fill;
    logic [INDEX_W-1:0]         r_index;

    // Registered read data and the stage that travels with it.
    logic signed [SAMPLE_W-1:0] r_rd_g;
    logic signed [SAMPLE_W-1:0] r_rd_k;
    logic                       r_a_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_grad_ok;
    logic                       r_emit_ok;
    logic [INDEX_W-1:0]         r_trig_idx;
    logic [INDEX_W-1:0]         r_out_idx;
    logic [KEEP_W-1:0]          r_total;
    logic                       r_end;

    logic                       accept;
    logic [KW-1:0]              k_dist;
    logic [KW-1:0]              wr_k;
    logic [KW-1:0]              addr_g_w;
    logic [KW-1:0]              addr_k_w;
    logic [AW-1:0]              addr_g;
    logic [AW-1:0]              addr_k;
    logic [FW-1:0]              n_fill;
    logic [AW-1:0]              n_wr_ptr;

    // Hold the input off while the queue could not take everything in flight.
    assign o_in_stall = (QSUM_W'(i_q_count) + QSUM_W'(r_a_valid)) >= QSUM_W'(QUEUE_DEPTH);
    assign accept     = i_in_valid & ~o_in_stall;

    // Read addresses: one gradient lag back and one full delay back.
    assign k_dist   = LAG_K + KW'(i_pre_eff);
    assign wr_k     = KW'(r_wr_ptr);
    assign addr_g_w = (wr_k >= LAG_K) ? (wr_k - LAG_K) : (wr_k + DEPTH_K - LAG_K);
    assign addr_k_w = (wr_k >= k_dist) ? (wr_k - k_dist) : (wr_k + DEPTH_K - k_dist);
    assign addr_g   = addr_g_w[AW-1:0];
    assign addr_k   = addr_k_w[AW-1:0];

    // The fill count stands in for clearing the history.
    assign n_fill   = (r_fill < FW'(FILL_CAP)) ? (r_fill + FW'(1)) : r_fill;
    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : (r_wr_ptr + AW'(1));

    // History memory: one write and two reads per transfer, read before write.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[r_wr_ptr] <= i_sample;
            r_rd_g        <= mem[addr_g];
            r_rd_k        <= mem[addr_k];
        end
    end

    // Write pointer, fill count and running index; a record end restarts them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_wr_ptr  <= '0;
            r_fill    <= '0;
            r_index   <= '0;
        end else begin
            r_a_valid <= accept;
            if (accept) begin
                if (i_block_end) begin
                    r_wr_ptr <= '0;
                    r_fill   <= '0;
                    r_index  <= '0;
                end else begin
                    r_wr_ptr <= n_wr_ptr;
                    r_fill   <= n_fill;
                    r_index  <= r_index + INDEX_W'(1);
                end
            end
        end
    end

    // Classification that travels alongside the memory read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample   <= i_sample;
            r_grad_ok  <= n_fill > FW'(GRADIENT_LAG);
            r_emit_ok  <= n_fill > FW'(k_dist);
            r_trig_idx <= r_index - INDEX_W'(GRADIENT_LAG);
            r_out_idx  <= r_index - INDEX_W'(k_dist);
            r_total    <= KEEP_W'(i_pre_eff) + KEEP_W'(i_post_count);
            r_end      <= i_block_end;
        end
    end

    // Every classified sample goes into the queue in the cycle after its transfer.
    assign o_push          = r_a_valid;
    assign o_item.sample   = r_sample;
    assign o_item.old_g    = r_rd_g;
    assign o_item.old_k    = r_rd_k;
    assign o_item.grad_ok  = r_grad_ok;
    assign o_item.emit_ok  = r_emit_ok;
    assign o_item.trig_idx = r_trig_idx;
    assign o_item.out_idx  = r_out_idx;
    assign o_item.total    = r_total;
    assign o_item.rec_end  = r_end;

endmodule

`default_nettype wire

// ----- hdl/gtzs_queue.sv -----
`default_nettype none

module gtzs_queue (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_push,
    input  gtzs_pkg::t_item              i_item,
    input  wire                          i_pop,
    output logic                         o_valid,
    output gtzs_pkg::t_item              o_item,
    output logic [gtzs_pkg::QCNT_W-1:0]  o_count
);
    import gtzs_pkg::*;

    t_item             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;

    assign n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : (r_wr + QPTR_W'(1));
    assign n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : (r_rd + QPTR_W'(1));

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- hdl/gtzs_back.sv -----
`default_nettype none

module gtzs_back (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_valid,
    input  gtzs_pkg::t_item                        i_item,
    output logic                                   o_pop,
    input  wire  signed [gtzs_pkg::SAMPLE_W-1:0]   i_threshold,
    input  wire  [gtzs_pkg::SPACING_W-1:0]         i_min_spacing,
    output logic                                   o_out_valid,
    input  wire                                    i_out_stall,
    output logic signed [gtzs_pkg::SAMPLE_W-1:0]   o_kept_sample,
    output logic [gtzs_pkg::INDEX_W-1:0]           o_sample_index,
    output logic                                   o_segment_first,
    output logic                                   o_segment_last
);
    import gtzs_pkg::*;

    // Trigger state.
    logic               r_in_peak;
    logic [INDEX_W-1:0] r_last_trigger;
    logic [KEEP_W-1:0]  r_keep;
    logic               r_first_pend;

    logic               n_in_peak;
    logic [INDEX_W-1:0] n_last_trigger;
    logic [KEEP_W-1:0]  n_keep;
    logic               n_first_pend;

    logic signed [SAMPLE_W-1:0] grad;
    logic                       spacing_ok;
    logic                       emit;
    logic                       seg_first;
    logic                       seg_last;

    // Output register.
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_kept_sample;
    logic [INDEX_W-1:0]         r_sample_index;
    logic                       r_segment_first;
    logic                       r_segment_last;

    // Take the next item whenever the output register is free or draining.
    assign o_pop = i_valid & (~r_out_valid | ~i_out_stall);

    // Trigger decision and segment bookkeeping for one item.
    always_comb begin
        grad           = i_item.sample - i_item.old_g;
        spacing_ok     = (i_item.trig_idx - r_last_trigger) >= INDEX_W'(i_min_spacing);
        n_in_peak      = r_in_peak;
        n_last_trigger = r_last_trigger;
        n_keep         = r_keep;
        n_first_pend   = r_first_pend;
        emit           = 1'b0;
        seg_first      = 1'b0;
        seg_last       = 1'b0;

        if (i_item.grad_ok) begin
            if (grad > i_threshold) begin
                n_in_peak = 1'b0;
            end else if (grad < i_threshold && !r_in_peak) begin
                n_last_trigger = i_item.trig_idx;
                if (spacing_ok) begin
                    n_in_peak = 1'b1;
                    if (i_item.total != '0) begin
                        if (r_keep == '0) begin
                            n_first_pend = 1'b1;
                        end
                        if (i_item.total > r_keep) begin
                            n_keep = i_item.total;
                        end
                    end
                end
            end
        end

        // An active segment emits the sample leaving the delay line.
        if (n_keep != '0) begin
            emit      = i_item.emit_ok;
            seg_first = n_first_pend;
            seg_last  = (n_keep == KEEP_W'(1));
            if (emit) begin
                n_first_pend = 1'b0;
            end
            n_keep = n_keep - KEEP_W'(1);
            if (n_keep == '0) begin
                n_first_pend = 1'b0;
            end
        end
    end

    // State update; a record end drops everything pending.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_peak      <= 1'b0;
            r_last_trigger <= '0;
            r_keep         <= '0;
            r_first_pend   <= 1'b0;
        end else if (o_pop) begin
            if (i_item.rec_end) begin
                r_in_peak      <= 1'b0;
                r_last_trigger <= '0;
                r_keep         <= '0;
                r_first_pend   <= 1'b0;
            end else begin
                r_in_peak      <= n_in_peak;
                r_last_trigger <= n_last_trigger;
                r_keep         <= n_keep;
                r_first_pend   <= n_first_pend;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kept_sample   <= i_item.old_k;
            r_sample_index  <= i_item.out_idx;
            r_segment_first <= seg_first;
            r_segment_last  <= seg_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kept_sample   = r_kept_sample;
    assign o_sample_index  = r_sample_index;
    assign o_segment_first = r_segment_first;
    assign o_segment_last  = r_segment_last;

endmodule

`default_nettype wire
